// File: sv/grid_flood_fill_reachability_defines.svh
// ----------------------------------------------------------------------------
// Grid flood fill reachability: assertion macros
// Concurrent assertion helpers used by the top-level RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef GRID_FLOOD_FILL_REACHABILITY_DEFINES_SVH
`define GRID_FLOOD_FILL_REACHABILITY_DEFINES_SVH

`ifndef SYNTH
// Antecedent holds in this cycle, consequent in the same cycle.
`define GFFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gffr assertion failed");
// Antecedent holds in this cycle, consequent in the next cycle.
`define GFFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gffr assertion failed");
`else
`define GFFR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GFFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/gffr_pkg.sv
// ----------------------------------------------------------------------------
// gffr_pkg
// Types, sizes, codes and helper functions of the grid reachability block.
// ----------------------------------------------------------------------------
package gffr_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int CNT_W       = $clog2(CELLS + 1);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int STACK_W     = ROW_W + COL_W;
    localparam int MAX_DIM     = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int PROD_W      = ROW_W + DIM_W;
    localparam int CFG_W       = 7;
    localparam int EXT_W       = (CFG_W > DIM_W) ? CFG_W : DIM_W;
    localparam int CFG_IDX_W   = 1;
    localparam int TILE_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_DIM_RESET = 7'd64;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    localparam logic [TILE_W-1:0] TILE_WALL    = 3'd0;
    localparam logic [TILE_W-1:0] TILE_FLOOR   = 3'd1;
    localparam logic [TILE_W-1:0] TILE_COLLECT = 3'd2;
    localparam logic [TILE_W-1:0] TILE_EXIT    = 3'd3;
    localparam logic [TILE_W-1:0] TILE_START   = 3'd4;

    localparam logic [1:0] NB_UP    = 2'd0;
    localparam logic [1:0] NB_DOWN  = 2'd1;
    localparam logic [1:0] NB_RIGHT = 2'd2;
    localparam logic [1:0] NB_LEFT  = 2'd3;

    typedef struct packed {
        logic              op;
        logic [TILE_W-1:0] tile;
    } t_in_item;

    typedef struct packed {
        logic             solvable;
        logic [CNT_W-1:0] reached_collectibles;
        logic [CNT_W-1:0] total_collectibles;
        logic             exit_reached;
        logic             start_found;
    } t_out_item;

    // Summary of the loaded grid, handed from the loader to the solver.
    typedef struct packed {
        logic              start_seen;
        logic [ADDR_W-1:0] start_addr;
        logic [CNT_W-1:0]  total;
        logic              exit_present;
    } t_load_info;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SEED,
        ST_PROBE_A,
        ST_PROBE_B,
        ST_POP,
        ST_POP_WAIT,
        ST_DONE
    } t_state;

    function automatic logic passable(input logic [TILE_W-1:0] t);
        return (t == TILE_FLOOR) || (t == TILE_COLLECT) || (t == TILE_EXIT) ||
               (t == TILE_START);
    endfunction

    // A zero register acts as one; a value above the maximum acts as the maximum.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (EXT_W'(v) > EXT_W'(maxv)) begin
            res = maxv;
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

endpackage

// File: sv/gffr_ram.sv
// ----------------------------------------------------------------------------
// gffr_ram
// Simple dual-port synchronous RAM, one write port and one registered read.
// ----------------------------------------------------------------------------
module gffr_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/gffr_loader.sv
// ----------------------------------------------------------------------------
// gffr_loader
// Raster-order cell loading: tile store writes, collectible count, exit flag,
// first start cell.
// ----------------------------------------------------------------------------
module gffr_loader
    import gffr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_solve,
    input  logic [TILE_W-1:0] i_tile,
    input  logic [CNT_W-1:0]  i_cells,
    output logic              o_tile_we,
    output logic [ADDR_W-1:0] o_tile_waddr,
    output logic [TILE_W-1:0] o_tile_wdata,
    output t_load_info        o_info
);

    logic             r_restart;
    logic             n_restart;
    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] n_pos;
    t_load_info       r_info;
    t_load_info       n_info;

    always_comb begin
        n_restart    = r_restart;
        n_pos        = r_pos;
        n_info       = r_info;
        o_tile_we    = 1'b0;
        o_tile_waddr = r_pos[ADDR_W-1:0];
        o_tile_wdata = i_tile;
        // The first load after a solve starts a fresh grid.
        if (i_load && r_restart) begin
            n_restart = 1'b0;
            n_pos     = '0;
            n_info    = '0;
        end
        if (i_load && (n_pos < i_cells)) begin
            o_tile_we    = 1'b1;
            o_tile_waddr = n_pos[ADDR_W-1:0];
            if (i_tile == TILE_COLLECT) begin
                n_info.total = n_info.total + CNT_W'(1);
            end
            if (i_tile == TILE_EXIT) begin
                n_info.exit_present = 1'b1;
            end
            if ((i_tile == TILE_START) && !n_info.start_seen) begin
                n_info.start_seen = 1'b1;
                n_info.start_addr = n_pos[ADDR_W-1:0];
            end
            n_pos = n_pos + CNT_W'(1);
        end
        if (i_solve) begin
            n_restart = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restart <= 1'b0;
            r_pos     <= '0;
            r_info    <= '0;
        end else begin
            r_restart <= n_restart;
            r_pos     <= n_pos;
            r_info    <= n_info;
        end
    end

    assign o_info = r_info;

endmodule

// File: sv/gffr_solver.sv
// ----------------------------------------------------------------------------
// gffr_solver
// Flood fill sequencer: clears the visited store, locates the start cell,
// then probes neighbors and pops cells from the stack memory.
// ----------------------------------------------------------------------------
module gffr_solver
    import gffr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIM_W-1:0]  i_cols,
    input  logic [DIM_W-1:0]  i_rows,
    input  t_load_info        i_info,
    input  logic              i_out_free,
    output logic              o_tile_re,
    output logic [ADDR_W-1:0] o_tile_raddr,
    input  logic [TILE_W-1:0] i_tile_rdata,
    output logic              o_busy,
    output logic              o_done,
    output t_out_item         o_result
);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_clr;
    logic [ADDR_W-1:0] r_rem;
    logic [ADDR_W-1:0] r_quo;
    logic [ROW_W-1:0]  r_cur_row;
    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_tgt_row;
    logic [COL_W-1:0]  r_tgt_col;
    logic [ADDR_W-1:0] r_paddr;
    logic [1:0]        r_nb;
    logic              r_seed;
    logic [CNT_W-1:0]  r_sp;
    logic [CNT_W-1:0]  r_reached;
    logic              r_exit_hit;

    logic [ROW_W-1:0]   w_tgt_row;
    logic [COL_W-1:0]   w_tgt_col;
    logic               w_tgt_ok;
    logic [PROD_W-1:0]  w_prod;
    logic [ADDR_W-1:0]  w_addr;
    logic               w_push;
    logic               w_rem_ge;
    logic               w_start_ok;
    logic [CNT_W-1:0]   w_sp_dec;

    logic               w_vis_we;
    logic [ADDR_W-1:0]  w_vis_waddr;
    logic               w_vis_wdata;
    logic               w_vis_re;
    logic               w_vis_rdata;
    logic               w_stk_we;
    logic               w_stk_re;
    logic [ADDR_W-1:0]  w_stk_raddr;
    logic [STACK_W-1:0] w_stk_rdata;

    gffr_ram #(.DEPTH(CELLS), .WIDTH(1)) u_visited (
        .i_clk   (i_clk),
        .i_we    (w_vis_we),
        .i_waddr (w_vis_waddr),
        .i_wdata (w_vis_wdata),
        .i_re    (w_vis_re),
        .i_raddr (w_addr),
        .o_rdata (w_vis_rdata)
    );

    gffr_ram #(.DEPTH(CELLS), .WIDTH(STACK_W)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (r_sp[ADDR_W-1:0]),
        .i_wdata ({r_tgt_row, r_tgt_col}),
        .i_re    (w_stk_re),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    // Neighbor under probe; in seed mode the probe is the start cell itself.
    always_comb begin
        w_tgt_row = r_cur_row;
        w_tgt_col = r_cur_col;
        w_tgt_ok  = 1'b1;
        if (!r_seed) begin
            case (r_nb)
                NB_UP: begin
                    w_tgt_ok  = (r_cur_row != '0);
                    w_tgt_row = r_cur_row - ROW_W'(1);
                end
                NB_DOWN: begin
                    w_tgt_ok  = (DIM_W'(r_cur_row) + DIM_W'(1)) < i_rows;
                    w_tgt_row = r_cur_row + ROW_W'(1);
                end
                NB_RIGHT: begin
                    w_tgt_ok  = (DIM_W'(r_cur_col) + DIM_W'(1)) < i_cols;
                    w_tgt_col = r_cur_col + COL_W'(1);
                end
                NB_LEFT: begin
                    w_tgt_ok  = (r_cur_col != '0);
                    w_tgt_col = r_cur_col - COL_W'(1);
                end
                default: begin
                    w_tgt_ok = 1'b0;
                end
            endcase
        end
    end

    assign w_prod     = PROD_W'(w_tgt_row) * PROD_W'(i_cols) + PROD_W'(w_tgt_col);
    assign w_addr     = w_prod[ADDR_W-1:0];
    assign w_push     = passable(i_tile_rdata) && !w_vis_rdata;
    assign w_rem_ge   = (ADDR_W + 1)'(r_rem) >= (ADDR_W + 1)'(i_cols);
    assign w_start_ok = i_info.start_seen && ((ADDR_W + 1)'(r_quo) < (ADDR_W + 1)'(i_rows));
    assign w_sp_dec   = r_sp - CNT_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (r_clr == CNT_W'(CELLS - 1)) begin
                    n_state = ST_SEED;
                end
            end
            ST_SEED: begin
                n_state = w_start_ok ? ST_PROBE_A : ST_DONE;
            end
            ST_PROBE_A: begin
                if (w_tgt_ok) begin
                    n_state = ST_PROBE_B;
                end else if (r_nb == NB_LEFT) begin
                    n_state = ST_POP;
                end
            end
            ST_PROBE_B: begin
                n_state = (r_seed || (r_nb == NB_LEFT)) ? ST_POP : ST_PROBE_A;
            end
            ST_POP: begin
                n_state = (r_sp == '0) ? ST_DONE : ST_POP_WAIT;
            end
            ST_POP_WAIT: begin
                n_state = ST_PROBE_A;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Memory controls and handshake outputs
    always_comb begin
        w_vis_we     = 1'b0;
        w_vis_waddr  = r_paddr;
        w_vis_wdata  = 1'b1;
        w_vis_re     = 1'b0;
        w_stk_we     = 1'b0;
        w_stk_re     = 1'b0;
        w_stk_raddr  = w_sp_dec[ADDR_W-1:0];
        o_tile_re    = 1'b0;
        o_tile_raddr = w_addr;
        o_busy       = (r_state != ST_IDLE);
        o_done       = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_vis_we    = 1'b1;
                w_vis_waddr = r_clr[ADDR_W-1:0];
                w_vis_wdata = 1'b0;
            end
            ST_PROBE_A: begin
                w_vis_re  = w_tgt_ok;
                o_tile_re = w_tgt_ok;
            end
            ST_PROBE_B: begin
                w_vis_we = w_push;
                w_stk_we = w_push;
            end
            ST_POP: begin
                w_stk_re = (r_sp != '0);
            end
            ST_DONE: begin
                o_done = i_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_clr      <= '0;
                r_rem      <= i_info.start_addr;
                r_quo      <= '0;
                r_sp       <= '0;
                r_reached  <= '0;
                r_exit_hit <= 1'b0;
            end
            ST_CLEAR: begin
                // Start row and column by repeated subtraction while the clear runs.
                r_clr <= r_clr + CNT_W'(1);
                if (w_rem_ge) begin
                    r_rem <= r_rem - ADDR_W'(i_cols);
                    r_quo <= r_quo + ADDR_W'(1);
                end
            end
            ST_SEED: begin
                r_cur_row <= r_quo[ROW_W-1:0];
                r_cur_col <= r_rem[COL_W-1:0];
                r_seed    <= 1'b1;
                r_nb      <= NB_UP;
            end
            ST_PROBE_A: begin
                r_tgt_row <= w_tgt_row;
                r_tgt_col <= w_tgt_col;
                r_paddr   <= w_addr;
                if (!w_tgt_ok) begin
                    r_nb <= r_nb + 2'd1;
                end
            end
            ST_PROBE_B: begin
                // Every pushed cell is popped later, so it is counted here.
                if (w_push) begin
                    r_sp <= r_sp + CNT_W'(1);
                    if (i_tile_rdata == TILE_COLLECT) begin
                        r_reached <= r_reached + CNT_W'(1);
                    end
                    if (i_tile_rdata == TILE_EXIT) begin
                        r_exit_hit <= 1'b1;
                    end
                end
                if (r_seed) begin
                    r_seed <= 1'b0;
                end else begin
                    r_nb <= r_nb + 2'd1;
                end
            end
            ST_POP: begin
                if (r_sp != '0) begin
                    r_sp <= w_sp_dec;
                end
            end
            ST_POP_WAIT: begin
                r_cur_row <= w_stk_rdata[STACK_W-1:COL_W];
                r_cur_col <= w_stk_rdata[COL_W-1:0];
                r_nb      <= NB_UP;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.solvable = i_info.start_seen && (r_reached == i_info.total) &&
                            (r_exit_hit == i_info.exit_present);
        o_result.reached_collectibles = r_reached;
        o_result.total_collectibles   = i_info.total;
        o_result.exit_reached         = r_exit_hit;
        o_result.start_found          = i_info.start_seen;
    end

endmodule

// File: sv/grid_flood_fill_reachability.sv
// ----------------------------------------------------------------------------
// grid_flood_fill_reachability
// Loads a tile grid cell by cell and answers 4-connected reachability from
// the start cell with a stack-based flood fill.
//
//   port group   direction  handshake               payload
//   input item   in         i_in_valid / o_in_stall  i_in_item (op, tile)
//   result item  out        o_out_valid / i_out_stall o_out_item
//   config       in         i_cfg_we                i_cfg_index, i_cfg_data
//
// Load items stream back to back while no solve is running.
// A solve item first clears the visited store, then pops cells from the stack
// and probes their neighbors, each probe reading the visited and tile
// memories through their single read ports.
// Reset is synchronous and active low; the memories need no clearing pass.
// Input is stalled while a solve runs; loads continue while a result waits.
// ----------------------------------------------------------------------------
`include "grid_flood_fill_reachability_defines.svh"

module grid_flood_fill_reachability
    import gffr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]  r_cfg_cols;
    logic [CFG_W-1:0]  r_cfg_rows;
    logic [DIM_W-1:0]  w_cols;
    logic [DIM_W-1:0]  w_rows;
    logic [CNT_W-1:0]  w_cells;
    logic              w_accept;
    logic              w_load;
    logic              w_solve;
    logic              w_busy;
    logic              w_done;
    logic              w_out_free;
    logic              r_out_valid;
    t_out_item         r_out_item;
    t_out_item         w_result;
    t_load_info        w_info;
    logic              w_tile_we;
    logic [ADDR_W-1:0] w_tile_waddr;
    logic [TILE_W-1:0] w_tile_wdata;
    logic              w_tile_re;
    logic [ADDR_W-1:0] w_tile_raddr;
    logic [TILE_W-1:0] w_tile_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= CFG_DIM_RESET;
            r_cfg_rows <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLUMNS: r_cfg_cols <= i_cfg_data;
                CFG_ROWS:    r_cfg_rows <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_cols = eff_dim(r_cfg_cols, DIM_W'(MAX_COLUMNS));
    assign w_rows = eff_dim(r_cfg_rows, DIM_W'(MAX_ROWS));

    assign w_cells = CNT_W'(w_cols) * CNT_W'(w_rows);

    assign o_in_stall = w_busy;
    assign w_accept   = i_in_valid && !w_busy;
    assign w_load     = w_accept && (i_in_item.op == OP_LOAD);
    assign w_solve    = w_accept && (i_in_item.op == OP_SOLVE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    gffr_loader u_loader (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_solve      (w_solve),
        .i_tile       (i_in_item.tile),
        .i_cells      (w_cells),
        .o_tile_we    (w_tile_we),
        .o_tile_waddr (w_tile_waddr),
        .o_tile_wdata (w_tile_wdata),
        .o_info       (w_info)
    );

    gffr_ram #(.DEPTH(CELLS), .WIDTH(TILE_W)) u_tile_store (
        .i_clk   (i_clk),
        .i_we    (w_tile_we),
        .i_waddr (w_tile_waddr),
        .i_wdata (w_tile_wdata),
        .i_re    (w_tile_re),
        .i_raddr (w_tile_raddr),
        .o_rdata (w_tile_rdata)
    );

    gffr_solver u_solver (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_solve),
        .i_cols       (w_cols),
        .i_rows       (w_rows),
        .i_info       (w_info),
        .i_out_free   (w_out_free),
        .o_tile_re    (w_tile_re),
        .o_tile_raddr (w_tile_raddr),
        .i_tile_rdata (w_tile_rdata),
        .o_busy       (w_busy),
        .o_done       (w_done),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A result is only produced when the output register can take it.
    `GFFR_ASSERT_SAME(a_done_room, i_clk, i_rst_n, w_done, w_out_free)
    // An accepted solve item blocks the input in the following cycle.
    `GFFR_ASSERT_NEXT(a_solve_stalls, i_clk, i_rst_n, w_solve, o_in_stall)
    // The output register only fills from a finished solve.
    `GFFR_ASSERT_SAME(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(w_done))

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for grid_flood_fill_reachability
// Streams tile grids of many sizes into the block, each followed by a solve
// item, and checks every reported reachability summary against a flood fill
// computed here from the same cells. Both handshakes idle and stall at random,
// with one long result hold and one stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module testbench;
    import gffr_pkg::*;

    localparam int HOLD_CYCLES   = 12000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int IDLE_PCT      = 21;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int RANDOM_SOLVES = 40;

    localparam logic [TILE_W-1:0] TILE_UNKNOWN_LO = TILE_START + 3'd1;
    localparam logic [TILE_W-1:0] TILE_UNKNOWN_HI = '1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_item             in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_COLUMNS;
    logic [CFG_W-1:0]     cfg_data = '0;

    t_in_item  grid_stream[$];
    t_out_item verdicts_due[$];
    t_out_item want_verdict;

    // Shadow of the block: configuration, loaded cells and the loader summary.
    logic [CFG_W-1:0]  columns_reg = CFG_DIM_RESET;
    logic [CFG_W-1:0]  rows_reg = CFG_DIM_RESET;
    logic [TILE_W-1:0] tile_copy[CELLS];
    bit                fill_mark[CELLS];
    int unsigned       fill_stack[CELLS];
    int unsigned       fill_depth;
    int unsigned       load_at = 0;
    int unsigned       first_start = 0;
    int unsigned       collect_count = 0;
    bit                start_loaded = 1'b0;
    bit                exit_loaded = 1'b0;
    bit                reload_due = 1'b0;
    int unsigned       written_mark = 0;

    bit          steady = 1'b0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned error_count = 0;
    int unsigned loads_done = 0;
    int unsigned results_seen = 0;
    int unsigned solvable_seen = 0;
    int unsigned widest_fill = 0;

    grid_flood_fill_reachability u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned limit);
        if (v == '0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic int unsigned grid_cells(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
        return clamp_dim(cols, MAX_COLUMNS) * clamp_dim(rows, MAX_ROWS);
    endfunction

    function automatic void mark_and_push(int unsigned a);
        logic [TILE_W-1:0] t;
        t = tile_copy[a];
        if (!fill_mark[a] && t != TILE_WALL && t <= TILE_START) begin
            fill_mark[a] = 1'b1;
            fill_stack[fill_depth] = a;
            fill_depth++;
        end
    endfunction

    function automatic t_out_item flood_verdict();
        int unsigned cols, rows, a, reached, cells;
        bit          exit_hit;
        t_out_item   v;
        cols = clamp_dim(columns_reg, MAX_COLUMNS);
        rows = clamp_dim(rows_reg, MAX_ROWS);
        reached = 0;
        cells = 0;
        exit_hit = 1'b0;
        fill_depth = 0;
        foreach (fill_mark[i]) fill_mark[i] = 1'b0;
        // A start that fell outside a shrunken grid runs no fill at all.
        if (start_loaded && first_start < cols * rows) begin
            mark_and_push(first_start);
            while (fill_depth > 0) begin
                fill_depth--;
                a = fill_stack[fill_depth];
                cells++;
                if (tile_copy[a] == TILE_COLLECT) reached++;
                if (tile_copy[a] == TILE_EXIT) exit_hit = 1'b1;
                if (a >= cols) mark_and_push(a - cols);
                if (a / cols + 1 < rows) mark_and_push(a + cols);
                if (a % cols + 1 < cols) mark_and_push(a + 1);
                if (a % cols > 0) mark_and_push(a - 1);
            end
        end
        if (cells > widest_fill) widest_fill = cells;
        v.solvable = start_loaded && reached == collect_count && exit_hit == exit_loaded;
        v.reached_collectibles = CNT_W'(reached);
        v.total_collectibles = CNT_W'(collect_count);
        v.exit_reached = exit_hit;
        v.start_found = start_loaded;
        return v;
    endfunction

    function automatic void absorb_item(t_in_item it);
        if (it.op == OP_SOLVE) begin
            verdicts_due.push_back(flood_verdict());
            reload_due = 1'b1;
        end else begin
            // The first load after a solve starts a fresh grid.
            if (reload_due) begin
                reload_due = 1'b0;
                load_at = 0;
                collect_count = 0;
                exit_loaded = 1'b0;
                start_loaded = 1'b0;
                first_start = 0;
            end
            if (load_at < grid_cells(columns_reg, rows_reg)) begin
                tile_copy[load_at] = it.tile;
                if (it.tile == TILE_COLLECT) collect_count++;
                if (it.tile == TILE_EXIT) exit_loaded = 1'b1;
                if (it.tile == TILE_START && !start_loaded) begin
                    start_loaded = 1'b1;
                    first_start = load_at;
                end
                load_at++;
            end
            loads_done++;
        end
    endfunction

    task automatic flag_error(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
        if (got !== want) begin
            flag_error($sformatf("result %0d: %s is %0d, expected %0d",
                                 results_seen, name, got, want));
        end
    endtask

    // Input side: one item per handshake, payload held while stalled.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) absorb_item(in_item);
            if (!in_valid || !in_stall) begin
                if (grid_stream.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_item <= grid_stream.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: checks each accepted result and drives the stall, including
    // the long hold that lets the block back up into its input.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (verdicts_due.size() == 0) begin
                    flag_error("result with no solve waiting for it");
                end else begin
                    want_verdict = verdicts_due.pop_front();
                    check_field("solvable", out_item.solvable, want_verdict.solvable);
                    check_field("reached_collectibles", out_item.reached_collectibles,
                                want_verdict.reached_collectibles);
                    check_field("total_collectibles", out_item.total_collectibles,
                                want_verdict.total_collectibles);
                    check_field("exit_reached", out_item.exit_reached,
                                want_verdict.exit_reached);
                    check_field("start_found", out_item.start_found,
                                want_verdict.start_found);
                    if (want_verdict.solvable) solvable_seen++;
                end
                results_seen++;
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !steady && $urandom_range(0, 99) < IDLE_PCT;
            end
        end
    end

    function automatic void push_cell(logic [TILE_W-1:0] t);
        t_in_item it;
        it.op = OP_LOAD;
        it.tile = t;
        grid_stream.push_back(it);
    endfunction

    function automatic void push_solve();
        t_in_item it;
        it.op = OP_SOLVE;
        it.tile = TILE_W'($urandom_range(0, TILE_UNKNOWN_HI));
        grid_stream.push_back(it);
    endfunction

    function automatic logic [TILE_W-1:0] pick_tile();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 22) return TILE_WALL;
        if (roll < 67) return TILE_FLOOR;
        if (roll < 82) return TILE_COLLECT;
        if (roll < 87) return TILE_EXIT;
        if (roll < 89) return TILE_START;
        return TILE_W'($urandom_range(TILE_UNKNOWN_LO, TILE_UNKNOWN_HI));
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) return CFG_W'($urandom_range(0, 8));
        if (roll < 97) return CFG_W'($urandom_range(9, 24));
        return CFG_W'($urandom_range(25, (1 << CFG_W) - 1));
    endfunction

    // Queues one grid for the current registers; returns the items that count.
    // Most grids are complete with one start; the rest are short, overfull,
    // empty, startless or carry several starts.
    function automatic int unsigned queue_grid(bit complete, bit with_solve);
        int unsigned cells, count, start_slot, roll, loaded;
        bit          place_start;
        cells = grid_cells(columns_reg, rows_reg);
        // A short grid keeps the cells of earlier grids past its end, so it is
        // only sent where every cell of the grid has been written before.
        roll = (complete || cells > written_mark) ? 0 : $urandom_range(0, 99);
        if (roll < 70) count = cells;
        else if (roll < 82) count = cells + $urandom_range(1, 4);
        else if (roll < 94) count = $urandom_range(0, cells - 1);
        else count = 0;
        place_start = complete || $urandom_range(0, 99) < 85;
        start_slot = $urandom_range(0, cells - 1);
        for (int unsigned i = 0; i < count; i++) begin
            push_cell((place_start && i == start_slot) ? TILE_START : pick_tile());
        end
        loaded = (count < cells) ? count : cells;
        if (loaded > written_mark) written_mark = loaded;
        if (with_solve) push_solve();
        return loaded + with_solve;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_grid(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, rows);
        columns_reg = cols;
        rows_reg = rows;
    endtask

    task automatic wait_drained();
        while (grid_stream.size() != 0 || in_valid || verdicts_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial begin
        int unsigned       random_items, phase, grids, solves_queued;
        bit                withhold;
        logic [CFG_W-1:0]  pick_cols, pick_rows;
        random_items = 0;
        solves_queued = 0;
        phase = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Start next to a collectible; the exit is sealed off by a wall and an
        // unknown code, and one more load falls past the end of the grid.
        set_grid(3, 2);
        push_cell(TILE_START);
        push_cell(TILE_COLLECT);
        push_cell(TILE_WALL);
        push_cell(TILE_WALL);
        push_cell(TILE_UNKNOWN_LO);
        push_cell(TILE_EXIT);
        push_cell(TILE_UNKNOWN_HI);
        push_solve();
        wait_drained();

        // A zero column count acts as one column. Two starts, then a repeated
        // solve, then a grid with no start at all.
        set_grid(0, 3);
        push_cell(TILE_COLLECT);
        push_cell(TILE_START);
        push_cell(TILE_START);
        push_solve();
        push_solve();
        push_cell(TILE_FLOOR);
        push_cell(TILE_COLLECT);
        push_cell(TILE_EXIT);
        push_solve();
        wait_drained();

        // The start lies in the last row, which the next setting cuts away.
        set_grid(1, 3);
        push_cell(TILE_FLOOR);
        push_cell(TILE_FLOOR);
        push_cell(TILE_START);
        wait_drained();
        set_grid(1, 2);
        push_solve();
        wait_drained();

        // A column count above the maximum acts as the full width: one
        // complete grid of two such rows.
        set_grid('1, 2);
        void'(queue_grid(1'b1, 1'b1));
        wait_drained();

        while (random_items < RANDOM_ITEMS || solves_queued < RANDOM_SOLVES) begin
            set_grid(pick_dim(), pick_dim());
            steady = (phase == 4);
            if (phase == 2) hold_req++;
            grids = (phase == 2 || phase == 4) ? 6 : $urandom_range(1, 3);
            withhold = $urandom_range(0, 99) < 15;
            for (int unsigned g = 0; g < grids; g++) begin
                random_items += queue_grid(1'b0, !(withhold && g == grids - 1));
            end
            solves_queued += grids;
            if (withhold) begin
                wait_drained();
                // The late solve may only cover cells that were written.
                do begin
                    pick_cols = pick_dim();
                    pick_rows = pick_dim();
                end while (grid_cells(pick_cols, pick_rows) > written_mark);
                set_grid(pick_cols, pick_rows);
                push_solve();
                random_items++;
            end
            wait_drained();
            steady = 1'b0;
            phase++;
        end

        $display("Run covered %0d cell loads and %0d solve results, %0d of them solvable,",
                 loads_done, results_seen, solvable_seen);
        $display("on grids from one cell up to 64 columns or rows; the largest fill visited %0d cells.",
                 widest_fill);
        if (error_count == 0) begin
            $display("grid_flood_fill_reachability: match");
        end else begin
            $display("grid_flood_fill_reachability: mismatch");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Run timed out with %0d results still expected.", verdicts_due.size());
        $display("grid_flood_fill_reachability: mismatch");
        $finish;
    end

endmodule
